// ===== hw/rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int HEADER_BYTES = 32;
  localparam int SIZE_W       = 27;

  localparam logic [31:0] SIZE_LIMIT        = 32'd100000000;
  localparam logic [31:0] HEAP_LIMIT_RESET  = 32'd1048576;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SIZE    = 3'd1;
  localparam logic [2:0] ST_HEAP    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  typedef struct packed {
    logic [31:0]       start;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

endpackage

// ===== hw/rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap block allocator with a block table in on-chip memory
// ----------------------------------------------------------------------------
// One request is taken at a time. The block table sits in a single-port-read
// memory and is scanned one entry per cycle; a reallocation that has to move
// scans the table twice. Requests rejected before any scan (bad size, null
// free, unused kind) go straight to the result. A finished result sits in the
// output register, and the next request is taken while it waits.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,   // req_size, req_address
  input  logic [2:0]    s_tuser,   // kind, address_present
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [119:0]  m_tdata,   // result_address, status, free_block_count,
                                   // free_byte_count, block_count, block_byte_count
  output logic          m_tuser,   // result_present
  input  logic          heap_limit_we,
  input  logic [31:0]   heap_limit_wdata
);

  localparam int IDX_W  = ffba_pkg::IDX_W;
  localparam int CNT_W  = ffba_pkg::CNT_W;
  localparam int SIZE_W = ffba_pkg::SIZE_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_TAKE   = 6'b000100,
    S_APPEND = 6'b001000,
    S_MARK   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic [31:0]      heap_limit;
  logic [CNT_W-1:0] used;
  logic [31:0]      heap_break;
  logic [CNT_W-1:0] avail_blocks;
  logic [31:0]      avail_bytes;
  logic [31:0]      all_bytes;

  logic [1:0]  kind;
  logic [31:0] req_size;
  logic [31:0] req_address;
  logic        fit_mode;
  logic        move_pending;

  logic [CNT_W-1:0] ptr;
  logic [IDX_W-1:0] chk;
  logic             chk_valid;

  logic [IDX_W-1:0]  hit_idx;
  ffba_pkg::entry_t  hit_entry;
  logic [IDX_W-1:0]  old_idx;
  ffba_pkg::entry_t  old_entry;

  logic [31:0] res_address;
  logic        res_present;
  logic [2:0]  res_status;

  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  ffba_pkg::entry_t tbl_wdata;
  ffba_pkg::entry_t tbl_rdata;

  logic        hit;
  logic        scan_miss;
  logic        size_bad;
  logic        table_full;
  logic [33:0] next_break;
  logic        heap_over;

  ffba_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  assign s_tready = (state == S_IDLE);

  assign size_bad   = (s_tdata[31:0] == 32'd0) || (s_tdata[31:0] > ffba_pkg::SIZE_LIMIT);
  assign table_full = (used >= CNT_W'(ffba_pkg::MAX_BLOCKS));
  assign next_break = {2'b00, heap_break} + 34'(ffba_pkg::HEADER_BYTES)
                    + {2'b00, req_size};
  assign heap_over  = (next_break > {2'b00, heap_limit});

  always_comb begin
    if (fit_mode) begin
      hit = chk_valid && tbl_rdata.is_free
            && ({{(32-SIZE_W){1'b0}}, tbl_rdata.size} >= req_size);
    end else begin
      hit = chk_valid && (({1'b0, tbl_rdata.start} + 33'(ffba_pkg::HEADER_BYTES))
                          == {1'b0, req_address});
    end
    scan_miss = !chk_valid && (ptr >= used);
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = hit_idx;
    tbl_wdata = hit_entry;
    unique case (state)
      S_TAKE: begin
        tbl_we    = 1'b1;
        tbl_waddr = hit_idx;
        tbl_wdata = '{start: hit_entry.start, size: hit_entry.size, is_free: 1'b0};
      end
      S_APPEND: begin
        tbl_we    = !table_full && !heap_over;
        tbl_waddr = used[IDX_W-1:0];
        tbl_wdata = '{start: heap_break, size: req_size[SIZE_W-1:0], is_free: 1'b0};
      end
      S_MARK: begin
        tbl_we    = !old_entry.is_free;
        tbl_waddr = old_idx;
        tbl_wdata = '{start: old_entry.start, size: old_entry.size, is_free: 1'b1};
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      heap_limit   <= ffba_pkg::HEAP_LIMIT_RESET;
      used         <= '0;
      heap_break   <= '0;
      avail_blocks <= '0;
      avail_bytes  <= '0;
      all_bytes    <= '0;
      chk_valid    <= 1'b0;
    end else begin
      if (heap_limit_we) begin
        heap_limit <= heap_limit_wdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind         <= s_tuser[1:0];
            req_size     <= s_tdata[31:0];
            req_address  <= s_tdata[63:32];
            res_address  <= '0;
            res_present  <= 1'b0;
            res_status   <= ffba_pkg::ST_OK;
            move_pending <= 1'b0;
            ptr          <= '0;
            chk_valid    <= 1'b0;
            unique case (s_tuser[1:0])
              ffba_pkg::KIND_ALLOC: begin
                fit_mode <= 1'b1;
                if (size_bad) begin
                  res_status <= ffba_pkg::ST_SIZE;
                  state      <= S_FINISH;
                end else begin
                  state <= S_SCAN;
                end
              end
              ffba_pkg::KIND_FREE: begin
                fit_mode <= 1'b0;
                state    <= s_tuser[2] ? S_SCAN : S_FINISH;
              end
              ffba_pkg::KIND_REALLOC: begin
                fit_mode <= !s_tuser[2];
                if (s_tdata[31:0] == 32'd0) begin
                  res_status <= ffba_pkg::ST_SIZE;
                  state      <= S_FINISH;
                end else if (!s_tuser[2] && size_bad) begin
                  res_status <= ffba_pkg::ST_SIZE;
                  state      <= S_FINISH;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end

        S_SCAN: begin
          chk       <= ptr[IDX_W-1:0];
          chk_valid <= (ptr < used);
          if (ptr < used) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (hit && fit_mode) begin
            hit_idx   <= chk;
            hit_entry <= tbl_rdata;
            state     <= S_TAKE;
          end else if (hit) begin
            old_idx   <= chk;
            old_entry <= tbl_rdata;
            if (kind == ffba_pkg::KIND_FREE) begin
              state <= S_MARK;
            end else if (req_size <= {{(32-SIZE_W){1'b0}}, tbl_rdata.size}) begin
              res_address <= req_address;
              res_present <= 1'b1;
              state       <= S_FINISH;
            end else if (req_size > ffba_pkg::SIZE_LIMIT) begin
              res_status <= ffba_pkg::ST_SIZE;
              state      <= S_FINISH;
            end else begin
              fit_mode     <= 1'b1;
              move_pending <= 1'b1;
              ptr          <= '0;
              chk_valid    <= 1'b0;
            end
          end else if (scan_miss) begin
            if (fit_mode) begin
              state <= S_APPEND;
            end else begin
              res_status <= ffba_pkg::ST_UNKNOWN;
              state      <= S_FINISH;
            end
          end
        end

        S_TAKE: begin
          avail_blocks <= avail_blocks - CNT_W'(1);
          avail_bytes  <= avail_bytes - {{(32-SIZE_W){1'b0}}, hit_entry.size};
          res_address  <= hit_entry.start + 32'(ffba_pkg::HEADER_BYTES);
          res_present  <= 1'b1;
          state        <= move_pending ? S_MARK : S_FINISH;
        end

        S_APPEND: begin
          if (table_full) begin
            res_status <= ffba_pkg::ST_FULL;
            state      <= S_FINISH;
          end else if (heap_over) begin
            res_status <= ffba_pkg::ST_HEAP;
            state      <= S_FINISH;
          end else begin
            used        <= used + CNT_W'(1);
            all_bytes   <= all_bytes + req_size;
            res_address <= heap_break + 32'(ffba_pkg::HEADER_BYTES);
            res_present <= 1'b1;
            heap_break  <= next_break[31:0];
            state       <= move_pending ? S_MARK : S_FINISH;
          end
        end

        S_MARK: begin
          if (!old_entry.is_free) begin
            avail_blocks <= avail_blocks + CNT_W'(1);
            avail_bytes  <= avail_bytes + {{(32-SIZE_W){1'b0}}, old_entry.size};
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_present;
            m_tdata  <= {7'd0, all_bytes, used, avail_bytes, avail_blocks,
                         res_status, res_address};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ffba_table.sv =====
// ----------------------------------------------------------------------------
// ffba_table
// block table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ffba_table (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ffba_pkg::IDX_W-1:0]  waddr,
  input  ffba_pkg::entry_t            wdata,
  input  logic [ffba_pkg::IDX_W-1:0]  raddr,
  output ffba_pkg::entry_t            rdata
);

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
